// File: sv/hammersley_point_generator_macros.svh
// assertion macros for the hammersley point generator checker
`ifndef HAMMERSLEY_POINT_GENERATOR_MACROS_SVH
`define HAMMERSLEY_POINT_GENERATOR_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define HPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HPG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/hpg_pkg.sv
// ----------------------------------------------------------------------------
// hpg_pkg
// shared register codes, widths and helpers of the hammersley point generator
// ----------------------------------------------------------------------------
package hpg_pkg;

   localparam int COUNT_W = 21;
   localparam int SEL_W   = 2;
   localparam int TRUNC_W = 5;
   localparam int CSR_W   = 2;

   typedef enum logic [CSR_W-1:0] {
      REG_POINT_COUNT   = 2'd0,
      REG_BASE_SELECT   = 2'd1,
      REG_TRUNCATE_BITS = 2'd2,
      REG_CENTER_OFFSET = 2'd3
   } csr_index_type;

   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET   = 21'd256;
   localparam logic [SEL_W-1:0]   BASE_SELECT_RESET   = 2'd0;
   localparam logic [TRUNC_W-1:0] TRUNCATE_BITS_RESET = 5'd0;
   localparam logic               CENTER_OFFSET_RESET = 1'b1;

   localparam logic [SEL_W-1:0] SEL_BASE3 = 2'd1;
   localparam logic [SEL_W-1:0] SEL_BASE5 = 2'd2;

   function automatic logic [2:0] base_value(input logic [SEL_W-1:0] sel);
      logic [2:0] b;
      case (sel)
         SEL_BASE3: b = 3'd3;
         SEL_BASE5: b = 3'd5;
         default:   b = 3'd2;
      endcase
      return b;
   endfunction

endpackage

// File: sv/hpg_div_cell.sv
// ----------------------------------------------------------------------------
// hpg_div_cell
// one restoring division step, registered: one quotient bit per cell
// ----------------------------------------------------------------------------
module hpg_div_cell
   import hpg_pkg::*;
#(
   parameter int DW = 23,
   parameter int QW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_quo,
   output logic          out_valid,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_den,
   output logic [QW-1:0] out_quo
);

   logic          valid_ff;
   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW:0]   shifted;
   logic          take;

   always_comb begin
      shifted = {in_rem, 1'b0};
      take    = shifted >= {1'b0, in_den};
      rem_in  = take ? DW'(shifted - {1'b0, in_den}) : shifted[DW-1:0];
      quo_in  = {in_quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff <= rem_in;
      den_ff <= in_den;
      quo_ff <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;

endmodule

// File: sv/hpg_div_chain.sv
// ----------------------------------------------------------------------------
// hpg_div_chain
// row of division cells giving floor(2^QW * num / den) for num below den
// ----------------------------------------------------------------------------
module hpg_div_chain
   import hpg_pkg::*;
#(
   parameter int DW = 23,
   parameter int QW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   output logic          out_valid,
   output logic [QW-1:0] out_quo
);

   logic          stage_valid [QW+1];
   logic [DW-1:0] stage_rem   [QW+1];
   logic [DW-1:0] stage_den   [QW+1];
   logic [QW-1:0] stage_quo   [QW+1];

   assign stage_valid[0] = in_valid;
   assign stage_rem[0]   = in_num;
   assign stage_den[0]   = in_den;
   assign stage_quo[0]   = '0;

   for (genvar c = 0; c < QW; c++) begin : g_cell
      hpg_div_cell #(.DW(DW), .QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[c]),
         .in_rem    (stage_rem[c]),
         .in_den    (stage_den[c]),
         .in_quo    (stage_quo[c]),
         .out_valid (stage_valid[c+1]),
         .out_rem   (stage_rem[c+1]),
         .out_den   (stage_den[c+1]),
         .out_quo   (stage_quo[c+1])
      );
   end

   assign out_valid = stage_valid[QW];
   assign out_quo   = stage_quo[QW];

endmodule

// File: sv/hammersley_point_generator.sv
// one point at a time: the digit reversal runs one digit per cycle over the base-b
// digits of the masked index (at most INDEX_BITS of them), then three quotients go
// through the division cell row (one quotient bit per cell) back to back
// rsp_valid is a one-cycle strobe
// reset: synchronous, restores the registers to their defaults and goes idle
// ----------------------------------------------------------------------------
// hammersley_point_generator
// 2d hammersley point in unsigned fixed point from a point index
// ----------------------------------------------------------------------------
module hammersley_point_generator
   import hpg_pkg::*;
#(
   parameter int INDEX_BITS    = 20,
   parameter int FRACTION_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [INDEX_BITS-1:0]    req_point_index,
   output logic                     rsp_valid,
   output logic [FRACTION_BITS-1:0] rsp_x_coord,
   output logic [FRACTION_BITS-1:0] rsp_y_coord,
   output logic                     rsp_index_out_of_range,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [COUNT_W-1:0]       csr_data
);

   localparam int IB = INDEX_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int PW = IB + 3;
   localparam int DW = (PW > COUNT_W) ? PW : COUNT_W;
   localparam int SH = IB + 3;
   localparam logic [SH:0] RECIP2 = (SH+1)'((64'd1 << SH) / 2);
   localparam logic [SH:0] RECIP3 = (SH+1)'((64'd1 << SH) / 3);
   localparam logic [SH:0] RECIP5 = (SH+1)'((64'd1 << SH) / 5);
   localparam logic [FB-1:0] FULL = '1;
   localparam logic [FB-1:0] HALF = FB'(64'd1 << (FB - 1));

   typedef enum logic [1:0] {ST_IDLE, ST_DIGIT, ST_FEED, ST_DRAIN} state_type;

   // configuration registers
   logic [COUNT_W-1:0] count_ff;
   logic [SEL_W-1:0]   sel_ff;
   logic [TRUNC_W-1:0] trunc_ff;
   logic               center_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= POINT_COUNT_RESET;
         sel_ff    <= BASE_SELECT_RESET;
         trunc_ff  <= TRUNCATE_BITS_RESET;
         center_ff <= CENTER_OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_POINT_COUNT:   count_ff  <= csr_data;
            REG_BASE_SELECT:   sel_ff    <= csr_data[SEL_W-1:0];
            REG_TRUNCATE_BITS: trunc_ff  <= csr_data[TRUNC_W-1:0];
            REG_CENTER_OFFSET: center_ff <= csr_data[0];
            default:           ;
         endcase
      end
   end

   state_type        state_ff;
   logic [IB-1:0]    idx_ff, m_ff;
   logic [PW-1:0]    r_ff, p_ff;
   logic [1:0]       feed_cnt_ff, got_cnt_ff;
   logic [FB-1:0]    xq_ff, yq_ff;
   logic             rsp_valid_ff;
   logic [FB-1:0]    x_out_ff, y_out_ff;
   logic             oor_out_ff;

   // mask width from ceil(log2 n) minus the truncation
   logic [COUNT_W-1:0] n_minus1;
   logic [TRUNC_W-1:0] nbits, keep;
   logic [IB-1:0]      mask;

   always_comb begin
      n_minus1 = count_ff - COUNT_W'(1);
      nbits    = '0;
      for (int b = 0; b < COUNT_W; b++) begin
         if (n_minus1[b]) nbits = TRUNC_W'(b + 1);
      end
      if (count_ff == '0) nbits = '0;
      keep = (nbits > trunc_ff) ? TRUNC_W'(nbits - trunc_ff) : '0;
      for (int b = 0; b < IB; b++) begin
         mask[b] = 32'(b) < 32'(keep);
      end
   end

   // one digit of the radical inverse: m / base by reciprocal with one correction
   logic [2:0]       base;
   logic [SH:0]      recip;
   logic [IB+SH:0]   prod;
   logic [IB-1:0]    q0, q_next;
   logic [IB+2:0]    rem0, rem1;
   logic             fix;
   logic [PW-1:0]    r_in, p_in;

   always_comb begin
      base = base_value(sel_ff);
      case (base)
         3'd3:    recip = RECIP3;
         3'd5:    recip = RECIP5;
         default: recip = RECIP2;
      endcase
      prod   = (IB+SH+1)'(m_ff) * (IB+SH+1)'(recip);
      q0     = prod[SH +: IB];
      rem0   = (IB+3)'(m_ff) - (IB+3)'(q0) * (IB+3)'(base);
      fix    = rem0 >= (IB+3)'(base);
      rem1   = fix ? rem0 - (IB+3)'(base) : rem0;
      q_next = fix ? q0 + IB'(1) : q0;
      r_in   = r_ff * PW'(base) + PW'(rem1[2:0]);
      p_in   = p_ff * PW'(base);
   end

   // operands for the division row
   logic [DW-1:0] y_num, y_den, n_ext, idx_ext;
   logic          y_sat, off_small;
   logic          feed_valid;
   logic [DW-1:0] feed_num, feed_den;
   logic          tail_valid;
   logic [FB-1:0] tail_quo;

   always_comb begin
      idx_ext   = DW'(idx_ff);
      n_ext     = DW'(count_ff);
      y_num     = idx_ext >> trunc_ff;
      y_den     = n_ext >> trunc_ff;
      y_sat     = (y_den == '0) || (y_num >= y_den);
      off_small = count_ff <= COUNT_W'(1);
      feed_valid = state_ff == ST_FEED;
      feed_num  = '0;
      feed_den  = DW'(1);
      case (feed_cnt_ff)
         2'd0: begin
            feed_num = DW'(r_ff);
            feed_den = DW'(p_ff);
         end
         2'd1: begin
            if (!y_sat) begin
               feed_num = y_num;
               feed_den = y_den;
            end
         end
         default: begin
            if (!off_small) begin
               feed_num = DW'(1);
               feed_den = n_ext;
            end
         end
      endcase
   end

   hpg_div_chain #(.DW(DW), .QW(FB)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (feed_valid),
      .in_num    (feed_num),
      .in_den    (feed_den),
      .out_valid (tail_valid),
      .out_quo   (tail_quo)
   );

   // final y with offset and saturation, done as the last quotient arrives
   logic [FB-1:0] y_base, offset, y_final;
   logic [FB:0]   y_sum;

   always_comb begin
      y_base = y_sat ? FULL : yq_ff;
      offset = '0;
      if (center_ff && (y_den != '0)) begin
         offset = off_small ? HALF : (tail_quo >> 1);
      end
      y_sum   = {1'b0, y_base} + {1'b0, offset};
      y_final = (y_den == '0) ? FULL
              : (y_sum > {1'b0, FULL}) ? FULL : y_sum[FB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         feed_cnt_ff  <= '0;
         got_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DRAIN) && tail_valid && (got_cnt_ff == 2'd2);
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  idx_ff      <= req_point_index;
                  m_ff        <= req_point_index & mask;
                  r_ff        <= '0;
                  p_ff        <= PW'(1);
                  feed_cnt_ff <= '0;
                  got_cnt_ff  <= '0;
                  state_ff    <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (m_ff == '0) begin
                  state_ff <= ST_FEED;
               end else begin
                  m_ff <= q_next;
                  r_ff <= r_in;
                  p_ff <= p_in;
               end
            end
            ST_FEED: begin
               feed_cnt_ff <= feed_cnt_ff + 2'd1;
               if (feed_cnt_ff == 2'd2) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (tail_valid) begin
                  got_cnt_ff <= got_cnt_ff + 2'd1;
                  case (got_cnt_ff)
                     2'd0: xq_ff <= tail_quo;
                     2'd1: yq_ff <= tail_quo;
                     default: begin
                        x_out_ff     <= xq_ff;
                        y_out_ff     <= y_final;
                        oor_out_ff   <= idx_ext >= n_ext;
                        state_ff     <= ST_IDLE;
                     end
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy                   = state_ff != ST_IDLE;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_x_coord            = x_out_ff;
   assign rsp_y_coord            = y_out_ff;
   assign rsp_index_out_of_range = oor_out_ff;

endmodule

// File: sv/hpg_checker.sv
// ----------------------------------------------------------------------------
// hpg_checker
// port-level checks of the hammersley point generator command handshake
// ----------------------------------------------------------------------------
`include "hammersley_point_generator_macros.svh"

module hpg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted command keeps the block busy until its beat goes out
   `HPG_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted command not busy")
   // the result beat is a single-cycle strobe
   `HPG_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   // a result beat finishes the item, so the block is free again
   `HPG_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "busy during result beat")
   // a result only follows a busy cycle
   `HPG_ASSERT_NEXT(a_rsp_cause, clock, reset, !busy, !rsp_valid, "result without command")

endmodule

bind hammersley_point_generator hpg_checker u_hpg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// File: test/tb_hammersley_point_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hammersley_point_generator
// drives point indexes under several register settings and compares every
// returned point with an independently computed hammersley point
// ----------------------------------------------------------------------------
module tb_hammersley_point_generator;
   import hpg_pkg::*;

   localparam int IW = 20;
   localparam int FW = 24;

   typedef struct {
      logic [FW-1:0] x;
      logic [FW-1:0] y;
      logic          oor;
   } point_type;

   int fail_count = 0;

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // register copy and expected point queue
   class point_scoreboard;
      logic [COUNT_W-1:0] count;
      logic [SEL_W-1:0]   sel;
      logic [TRUNC_W-1:0] trunc;
      logic               offset;
      point_type          pending[$];

      function new();
         count = POINT_COUNT_RESET;
         sel = BASE_SELECT_RESET;
         trunc = TRUNCATE_BITS_RESET;
         offset = CENTER_OFFSET_RESET;
      endfunction

      function void write_reg(csr_index_type idx, logic [COUNT_W-1:0] v);
         case (idx)
            REG_POINT_COUNT:   count = v;
            REG_BASE_SELECT:   sel = v[SEL_W-1:0];
            REG_TRUNCATE_BITS: trunc = v[TRUNC_W-1:0];
            REG_CENTER_OFFSET: offset = v[0];
            default:           ;
         endcase
      endfunction

      function point_type hammersley(logic [IW-1:0] idx);
         point_type pt;
         longint unsigned b, nb, kept, m, r, p, den, y, rem, q;
         b = (sel == SEL_BASE3) ? 3 : (sel == SEL_BASE5) ? 5 : 2;
         nb = 0;
         while (nb < 40 && (64'd1 << nb) < count) nb++;
         kept = (nb > trunc) ? nb - trunc : 0;
         m = (kept > 0) ? idx & ((64'd1 << kept) - 1) : 0;
         r = 0;
         p = 1;
         while (m > 0) begin
            r = r * b + m % b;
            p = p * b;
            m = m / b;
         end
         rem = r;
         q = 0;
         for (int k = 0; k < FW; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= p) begin
               rem -= p;
               q |= 1;
            end
         end
         den = count >> trunc;
         if (den == 0) y = (64'd1 << FW) - 1;
         else begin
            y = ((64'(idx) >> trunc) << FW) / den;
            if (y >= (64'd1 << FW)) y = (64'd1 << FW) - 1;
            if (offset) begin
               y += (64'd1 << (FW - 1)) / count;
               if (y >= (64'd1 << FW)) y = (64'd1 << FW) - 1;
            end
         end
         pt.x = q[FW-1:0];
         pt.y = y[FW-1:0];
         pt.oor = (idx >= count);
         return pt;
      endfunction

      function void note_index(logic [IW-1:0] idx);
         pending.push_back(hammersley(idx));
      endfunction

      task check_point(point_type got);
         point_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected point x=%h y=%h", got.x, got.y));
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x)
            report_mismatch($sformatf("x_coord got %h want %h", got.x, want.x));
         if (got.y !== want.y)
            report_mismatch($sformatf("y_coord got %h want %h", got.y, want.y));
         if (got.oor !== want.oor)
            report_mismatch($sformatf("out of range got %b want %b", got.oor, want.oor));
      endtask
   endclass

   logic               clock, reset, start, busy;
   logic [IW-1:0]      req_point_index;
   logic               rsp_valid, rsp_index_out_of_range;
   logic [FW-1:0]      rsp_x_coord, rsp_y_coord;
   logic               csr_valid, csr_ready;
   logic [CSR_W-1:0]   csr_index;
   logic [COUNT_W-1:0] csr_data;

   point_scoreboard points = new();

   hammersley_point_generator u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      point_type got;
      if (!reset && rsp_valid) begin
         got.x = rsp_x_coord;
         got.y = rsp_y_coord;
         got.oor = rsp_index_out_of_range;
         points.check_point(got);
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_index(logic [IW-1:0] idx, bit gaps);
      start <= 1'b1;
      req_point_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      points.note_index(idx);
      start <= 1'b0;
      @(posedge clock);
      if (gaps) idle_gap();
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (points.pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [COUNT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      points.write_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [COUNT_W-1:0] n, logic [SEL_W-1:0] s,
                           logic [TRUNC_W-1:0] t, logic o);
      drain();
      write_csr(REG_POINT_COUNT, n);
      write_csr(REG_BASE_SELECT, COUNT_W'(s));
      write_csr(REG_TRUNCATE_BITS, COUNT_W'(t));
      write_csr(REG_CENTER_OFFSET, COUNT_W'(o));
   endtask

   // mostly in-range indexes, some anywhere
   function automatic logic [IW-1:0] pick_index();
      logic [IW-1:0] r;
      r = IW'($urandom);
      if ($urandom_range(0, 4) != 0 && points.count != 0)
         r = IW'($urandom_range(0, (points.count > (1 << IW)) ? (1 << IW) - 1
                                                              : points.count - 1));
      return r;
   endfunction

   initial begin
      logic [COUNT_W-1:0] n;
      reset = 1'b1;
      start = 1'b0;
      req_point_index = '0;
      csr_valid = 1'b0;
      csr_index = REG_POINT_COUNT;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes, each base, edge cases
      send_index('0, 1'b0);
      send_index(20'd255, 1'b0);
      send_index(20'd256, 1'b0);
      send_index('1, 1'b0);
      send_index(20'h55555, 1'b1);
      set_regs(21'd1048576, 2'd1, 5'd0, 1'b0);
      send_index('1, 1'b0);
      send_index(20'd123456, 1'b0);
      set_regs(21'd1000, 2'd2, 5'd3, 1'b1);
      send_index(20'd999, 1'b0);
      send_index(20'd1000, 1'b0);
      set_regs(21'd300, 2'd3, 5'd20, 1'b1);
      send_index(20'd77, 1'b0);
      send_index('1, 1'b0);
      set_regs(21'd1, 2'd0, 5'd31, 1'b1);
      send_index('0, 1'b0);
      send_index(20'd5, 1'b0);
      set_regs(21'd0, 2'd1, 5'd0, 1'b1);
      send_index('0, 1'b0);
      send_index(20'd9, 1'b0);
      set_regs(21'h1FFFFF, 2'd2, 5'd1, 1'b1);
      send_index('1, 1'b0);
      send_index(20'haaaaa, 1'b0);

      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 3))
            0: n = COUNT_W'($urandom_range(1, 64));
            1: n = COUNT_W'($urandom_range(1, 4096));
            2: n = COUNT_W'($urandom_range(1, 21'h1FFFFF));
            default: n = COUNT_W'(1) << $urandom_range(0, 20);
         endcase
         set_regs(n, SEL_W'($urandom_range(0, 3)),
                  TRUNC_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 6)),
                  1'($urandom_range(0, 1)));
         for (int k = 0; k < 125; k++) begin
            send_index(pick_index(), $urandom_range(0, 2) != 0);
            if (k == 60) drain();
         end
      end

      drain();
      if (fail_count == 0 && points.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
